[rtl/core/dlsg_pkg.sv]
// ----------------------------------------------------------------------------
// dlsg_pkg
// Shared types, widths and helpers of the dashed line segment generator.
// ----------------------------------------------------------------------------
package dlsg_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned MAX_DASHES = 64;
  localparam int unsigned UNIT_FRAC = 28;
  localparam int unsigned MAG_W     = COORD_W + 1;          // |end - start|
  localparam int unsigned RAD_W     = 2 * MAG_W;            // sum of squares
  localparam int unsigned LEN_W     = MAG_W;                // floor sqrt
  localparam int unsigned UNIT_W    = UNIT_FRAC + 1;        // unit magnitude
  localparam int unsigned NUM_W     = MAG_W + UNIT_FRAC;    // divide numerator
  localparam int unsigned DIST_W    = LEN_W + 2;            // distances
  localparam int unsigned PROD_W    = UNIT_W + DIST_W;
  localparam int unsigned CNT_W     = $clog2(MAX_DASHES + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified line, handed from the front end to the segment walker
  typedef struct packed {
    coord_t              sx;
    coord_t              sy;
    coord_t              ex;
    coord_t              ey;
    coord_t              on;
    coord_t              off;
    logic [LEN_W-1:0]    len;
    logic [UNIT_W-1:0]   ux;
    logic [UNIT_W-1:0]   uy;
    logic                ux_neg;
    logic                uy_neg;
    logic                solid;
  } line_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQUARE, F_SUM, F_SQRT, F_DIV, F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE, B_MUL, B_OUT
  } back_state_e;

  // Round a registered unit*distance product, apply sign, add start, saturate
  function automatic coord_t point_at(coord_t start, logic neg,
                                      logic [PROD_W-1:0] prod);
    logic [PROD_W:0]             rnd;
    logic [PROD_W-UNIT_FRAC:0]   q;
    logic signed [PROD_W-UNIT_FRAC+2:0] off;
    logic signed [PROD_W-UNIT_FRAC+2:0] sum;
    logic signed [PROD_W-UNIT_FRAC+2:0] hi;
    logic signed [PROD_W-UNIT_FRAC+2:0] lo;
    rnd = {1'b0, prod} + ((PROD_W+1)'(1) << (UNIT_FRAC - 1));
    q   = rnd[PROD_W:UNIT_FRAC];
    off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = off + (PROD_W-UNIT_FRAC+3)'(start);
    hi  = (PROD_W-UNIT_FRAC+3)'({1'b0, {(COORD_W-1){1'b1}}});
    lo  = -hi - 1;
    if (sum > hi) begin
      return coord_t'(hi);
    end else if (sum < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(sum);
  endfunction

endpackage

[rtl/core/dashed_line_segment_generator_top.sv]
// Front end: a 25-step square root finds the length and a 29-step division the
// unit direction; a solid line skips the division. The front end takes a new
// line only when idle, but works on it while the walker, behind a two-entry
// queue, still splits earlier lines; the walker emits each segment through
// states B_MUL then B_OUT and stalls in B_OUT on output back-pressure.
// Reset: rst_ni asynchronous active low; clears both sequencers, queue, output.
// ----------------------------------------------------------------------------
// dashed_line_segment_generator_top
// Splits a line into dash segments along its unit direction.
// ----------------------------------------------------------------------------
module dashed_line_segment_generator_top
  import dlsg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // start_x, start_y, end_x, end_y, dash_on, dash_off (lowest bits first)
  input  logic [6*COORD_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y (lowest bits first)
  output logic [4*COORD_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o,
  // truncated
  output logic                 m_axis_tuser_o
);

  logic  push, full, pop, empty;
  line_t push_line, pop_line;

  dlsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .push_o      (push),
    .push_line_o (push_line),
    .full_i      (full)
  );

  dlsg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_line_i (push_line),
    .full_o      (full),
    .pop_i       (pop),
    .pop_line_o  (pop_line),
    .empty_o     (empty)
  );

  dlsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .line_i      (pop_line),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_trunc_o (m_axis_tuser_o)
  );

endmodule

[rtl/core/dlsg_front.sv]
// ----------------------------------------------------------------------------
// dlsg_front
// Accepts lines, finds length by iterative square root, classifies the line
// as solid or dashed, and finds unit direction of a dashed line by iterative division.
// ----------------------------------------------------------------------------
module dlsg_front
  import dlsg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [6*COORD_W-1:0]    in_data_i,
  output logic                    push_o,
  output line_t                   push_line_o,
  input  logic                    full_i
);

  front_state_e state_q, state_d;
  line_t        ln_q, ln_d;
  logic [MAG_W-1:0]  dxm_q, dxm_d, dym_q, dym_d;
  logic [RAD_W-2:0]  sqx_q, sqx_d, sqy_q, sqy_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [LEN_W-1:0]  root_q, root_d;
  logic [LEN_W+1:0]  srem_q, srem_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [UNIT_W-1:0] nx_q, nx_d, ny_q, ny_d;
  logic [LEN_W-1:0]  rx_q, rx_d, ry_q, ry_d;

  coord_t             a_sx, a_sy, a_ex, a_ey;
  logic signed [MAG_W-1:0] a_dx, a_dy;
  logic [LEN_W+3:0]   s_t;
  logic [LEN_W+1:0]   s_trial;
  logic [NUM_W-1:0]   n_x, n_y;
  logic [LEN_W:0]     d_tx, d_ty;

  assign a_sx = in_data_i[0*COORD_W +: COORD_W];
  assign a_sy = in_data_i[1*COORD_W +: COORD_W];
  assign a_ex = in_data_i[2*COORD_W +: COORD_W];
  assign a_ey = in_data_i[3*COORD_W +: COORD_W];
  assign a_dx = MAG_W'(a_ex) - MAG_W'(a_sx);
  assign a_dy = MAG_W'(a_ey) - MAG_W'(a_sy);

  assign in_ready_o  = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_line_o = ln_q;

  // Next state and datapath steps
  always_comb begin
    state_d = state_q;
    ln_d    = ln_q;
    dxm_d   = dxm_q;
    dym_d   = dym_q;
    sqx_d   = sqx_q;
    sqy_d   = sqy_q;
    rad_d   = rad_q;
    root_d  = root_q;
    srem_d  = srem_q;
    cnt_d   = cnt_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    s_t     = {srem_q, rad_q[RAD_W-1 -: 2]};
    s_trial = {root_q, 2'b01};
    n_x     = {dxm_q, {UNIT_FRAC{1'b0}}} + NUM_W'(root_q >> 1);
    n_y     = {dym_q, {UNIT_FRAC{1'b0}}} + NUM_W'(root_q >> 1);
    d_tx    = {rx_q, nx_q[UNIT_W-1]};
    d_ty    = {ry_q, ny_q[UNIT_W-1]};
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          ln_d.sx     = a_sx;
          ln_d.sy     = a_sy;
          ln_d.ex     = a_ex;
          ln_d.ey     = a_ey;
          ln_d.on     = in_data_i[4*COORD_W +: COORD_W];
          ln_d.off    = in_data_i[5*COORD_W +: COORD_W];
          ln_d.ux_neg = a_dx[MAG_W-1];
          ln_d.uy_neg = a_dy[MAG_W-1];
          dxm_d       = a_dx[MAG_W-1] ? MAG_W'(-a_dx) : MAG_W'(a_dx);
          dym_d       = a_dy[MAG_W-1] ? MAG_W'(-a_dy) : MAG_W'(a_dy);
          state_d     = F_SQUARE;
        end
      end
      F_SQUARE: begin
        sqx_d   = (RAD_W-1)'(dxm_q * dxm_q);
        sqy_d   = (RAD_W-1)'(dym_q * dym_q);
        state_d = F_SUM;
      end
      F_SUM: begin
        rad_d   = {1'b0, sqx_q} + {1'b0, sqy_q};
        root_d  = '0;
        srem_d  = '0;
        cnt_d   = 5'(LEN_W - 1);
        state_d = F_SQRT;
      end
      F_SQRT: begin
        // One radicand bit pair per cycle
        rad_d = rad_q << 2;
        if (s_t >= {2'b00, s_trial}) begin
          srem_d = (LEN_W+2)'(s_t - {2'b00, s_trial});
          root_d = {root_q[LEN_W-2:0], 1'b1};
        end else begin
          srem_d = s_t[LEN_W+1:0];
          root_d = {root_q[LEN_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = F_DIV;
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'(LEN_W - 1)) begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      F_DIV: begin
        // First cycle after root: classify and load numerators
        if (cnt_q == 5'h1f) begin
          ln_d.len   = root_q;
          ln_d.solid = (root_q == '0) || ln_q.on[COORD_W-1] ||
                       ln_q.off[COORD_W-1] || (ln_q.off == '0);
          rx_d  = LEN_W'(n_x[NUM_W-1:UNIT_W]);
          nx_d  = n_x[UNIT_W-1:0];
          ry_d  = LEN_W'(n_y[NUM_W-1:UNIT_W]);
          ny_d  = n_y[UNIT_W-1:0];
          cnt_d = 5'(UNIT_W - 1);
          if (ln_d.solid) begin
            state_d = F_PUSH;
          end
        end else begin
          // One quotient bit per cycle for both components
          nx_d = {nx_q[UNIT_W-2:0], 1'b0};
          ny_d = {ny_q[UNIT_W-2:0], 1'b0};
          if (d_tx >= {1'b0, ln_q.len}) begin
            rx_d = LEN_W'(d_tx - {1'b0, ln_q.len});
            nx_d[0] = 1'b1;
          end else begin
            rx_d = d_tx[LEN_W-1:0];
          end
          if (d_ty >= {1'b0, ln_q.len}) begin
            ry_d = LEN_W'(d_ty - {1'b0, ln_q.len});
            ny_d[0] = 1'b1;
          end else begin
            ry_d = d_ty[LEN_W-1:0];
          end
          cnt_d = cnt_q - 5'd1;
          if (cnt_q == '0) begin
            ln_d.ux = nx_d;
            ln_d.uy = ny_d;
            state_d = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    ln_q   <= ln_d;
    dxm_q  <= dxm_d;
    dym_q  <= dym_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
  end

endmodule

[rtl/core/dlsg_queue.sv]
// ----------------------------------------------------------------------------
// dlsg_queue
// Two-entry queue of classified lines between front end and walker.
// ----------------------------------------------------------------------------
module dlsg_queue
  import dlsg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  line_t push_line_i,
  output logic  full_o,
  input  logic  pop_i,
  output line_t pop_line_o,
  output logic  empty_o
);

  line_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign pop_line_o = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_line_i;
    end
  end

endmodule

[rtl/core/dlsg_back.sv]
// ----------------------------------------------------------------------------
// dlsg_back
// Walks one line along its dash pattern and drives one segment per
// output transaction through a registered output stage.
// ----------------------------------------------------------------------------
module dlsg_back
  import dlsg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  line_t                line_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [4*COORD_W-1:0] out_data_o,
  output logic                 out_last_o,
  output logic                 out_trunc_o
);

  back_state_e state_q, state_d;
  line_t       ln_q, ln_d;
  logic [DIST_W-1:0] cons_q, cons_d, dend_q, dend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
  logic              ov_q, ov_d, ol_q, ol_d, ot_q, ot_d;
  logic [4*COORD_W-1:0] od_q, od_d;

  logic              slot_free;
  logic [DIST_W-1:0] on_e, off_e, len_e, dend_c, next_c;
  coord_t            psx, psy, pex, pey;

  assign slot_free = !ov_q || out_ready_i;
  assign on_e      = DIST_W'(ln_q.on[COORD_W-2:0]);
  assign off_e     = DIST_W'(ln_q.off[COORD_W-2:0]);
  assign len_e     = DIST_W'(ln_q.len);
  assign dend_c    = cons_q + on_e;
  assign next_c    = dend_q + off_e;
  assign psx       = point_at(ln_q.sx, ln_q.ux_neg, p0x_q);
  assign psy       = point_at(ln_q.sy, ln_q.uy_neg, p0y_q);
  assign pex       = point_at(ln_q.sx, ln_q.ux_neg, p1x_q);
  assign pey       = point_at(ln_q.sy, ln_q.uy_neg, p1y_q);

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;
  assign out_trunc_o = ot_q;

  // Walk the dash pattern
  always_comb begin
    state_d = state_q;
    ln_d    = ln_q;
    cons_d  = cons_q;
    dend_d  = dend_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    ol_d    = ol_q;
    ot_d    = ot_q;
    od_d    = od_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          ln_d    = line_i;
          cons_d  = '0;
          cnt_d   = '0;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        dend_d  = dend_c;
        state_d = B_OUT;
      end
      B_OUT: begin
        if (slot_free) begin
          ov_d = 1'b1;
          ot_d = 1'b0;
          ol_d = 1'b1;
          if (ln_q.solid) begin
            od_d    = {ln_q.ey, ln_q.ex, ln_q.sy, ln_q.sx};
            state_d = B_IDLE;
          end else if (dend_q >= len_e) begin
            od_d    = {ln_q.ey, ln_q.ex, psy, psx};
            state_d = B_IDLE;
          end else begin
            od_d = {pey, pex, psy, psx};
            if (next_c >= len_e) begin
              state_d = B_IDLE;
            end else if (cnt_q == CNT_W'(MAX_DASHES - 1)) begin
              ot_d    = 1'b1;
              state_d = B_IDLE;
            end else begin
              ol_d    = 1'b0;
              cons_d  = next_c;
              cnt_d   = cnt_q + CNT_W'(1);
              state_d = B_MUL;
            end
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  // Register products of unit and distance, and the payload
  always_ff @(posedge clk_i) begin
    ln_q   <= ln_d;
    cons_q <= cons_d;
    dend_q <= dend_d;
    ol_q   <= ol_d;
    ot_q   <= ot_d;
    od_q   <= od_d;
    p0x_q  <= ln_q.ux * cons_q;
    p0y_q  <= ln_q.uy * cons_q;
    p1x_q  <= ln_q.ux * dend_c;
    p1y_q  <= ln_q.uy * dend_c;
  end

`ifndef SYNTHESIS
  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ot_q) |-> ol_q) else $error("truncated segment not last");
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == B_MUL)) else $error("pop did not start a line");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) |-> (cnt_q <= CNT_W'(MAX_DASHES - 1)))
    else $error("dash count past limit");
`endif

endmodule

[tb/sv/tb_dashed_line_segment_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dashed_line_segment_generator_top
// Drives lines into the dash generator and checks every emitted segment
// against a predictor that walks the line in the same fixed point steps.
// ----------------------------------------------------------------------------
module tb_dashed_line_segment_generator_top;
  import dlsg_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     NUM_RANDOM  = 360;
  localparam longint CMAX        = 64'sd8388607;
  localparam longint CMIN        = -64'sd8388608;

  // Expected segments of accepted lines, oldest first
  class dash_scoreboard;
    typedef struct {
      coord_t sx, sy, ex, ey;
      bit     last, trunc;
    } seg_t;

    seg_t   pending[$];
    int     errors, lines, segs, truncs, solids;

    function longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned root, rem, trial;
      root = 0;
      rem  = 0;
      for (int i = 31; i >= 0; i--) begin
        rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    // Direction component with 28 fraction bits, rounded half away from zero
    function longint direction(longint d, longint unsigned len);
      longint unsigned n, q;
      n = longint'(d < 0 ? -d : d) << UNIT_FRAC;
      q = (n + len / 2) / len;
      return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint walk_point(longint start, longint unit, longint along);
      longint unsigned m, q;
      longint          offs;
      m    = longint'(unit < 0 ? -unit : unit) * along;
      q    = (m + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      offs = unit < 0 ? -longint'(q) : longint'(q);
      return clamp(start + offs);
    endfunction

    function void push_seg(longint ax, longint ay, longint bx, longint by,
                           bit last, bit trunc);
      seg_t s;
      s.sx    = coord_t'(ax);
      s.sy    = coord_t'(ay);
      s.ex    = coord_t'(bx);
      s.ey    = coord_t'(by);
      s.last  = last;
      s.trunc = trunc;
      pending.push_back(s);
    endfunction

    // Note an accepted line and queue the dashes it must produce
    function void note_line(logic [6*COORD_W-1:0] d);
      coord_t          f[6];
      longint          sx, sy, ex, ey, on, off, dx, dy, ux, uy, used, dend;
      longint unsigned len;
      int              cnt;
      for (int k = 0; k < 6; k++) f[k] = d[k*COORD_W +: COORD_W];
      sx = longint'(f[0]); sy = longint'(f[1]); ex = longint'(f[2]);
      ey = longint'(f[3]); on = longint'(f[4]); off = longint'(f[5]);
      dx = ex - sx;
      dy = ey - sy;
      len = floor_root(longint'(dx * dx) + longint'(dy * dy));
      lines++;
      if (len == 0 || on < 0 || off <= 0) begin
        solids++;
        push_seg(sx, sy, ex, ey, 1, 0);
        return;
      end
      ux   = direction(dx, len);
      uy   = direction(dy, len);
      used = 0;
      cnt  = 0;
      forever begin
        dend = used + on;
        if (dend >= longint'(len)) begin
          push_seg(walk_point(sx, ux, used), walk_point(sy, uy, used), ex, ey, 1, 0);
          return;
        end
        if (dend + off >= longint'(len) || cnt + 1 >= MAX_DASHES) begin
          push_seg(walk_point(sx, ux, used), walk_point(sy, uy, used),
                   walk_point(sx, ux, dend), walk_point(sy, uy, dend), 1,
                   dend + off < longint'(len));
          return;
        end
        push_seg(walk_point(sx, ux, used), walk_point(sy, uy, used),
                 walk_point(sx, ux, dend), walk_point(sy, uy, dend), 0, 0);
        used = dend + off;
        cnt++;
      end
    endfunction

    task report(string what);
      $display("ERROR segment %0d: %s", segs, what);
      errors++;
    endtask

    // Compare one output transaction with the oldest expected segment
    task check_seg(logic [4*COORD_W-1:0] d, logic last, logic user);
      seg_t   s;
      coord_t got[4];
      coord_t want[4];
      for (int k = 0; k < 4; k++) got[k] = d[k*COORD_W +: COORD_W];
      if (pending.size() == 0) begin
        report("unexpected segment");
        return;
      end
      s = pending.pop_front();
      want = '{s.sx, s.sy, s.ex, s.ey};
      segs++;
      if (user) truncs++;
      for (int k = 0; k < 4; k++)
        if (got[k] !== want[k])
          report($sformatf("coord %0d got %0d want %0d", k, got[k], want[k]));
      if (last !== s.last) report($sformatf("last got %b want %b", last, s.last));
      if (user !== s.trunc) report($sformatf("truncated got %b want %b", user, s.trunc));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [6*COORD_W-1:0] s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [4*COORD_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 m_axis_tuser_o;

  dash_scoreboard sb = new();
  bit             idle_on = 1'b1;
  bit             hold_req = 1'b0;
  longint         cycles = 0;

  dashed_line_segment_generator_top uut (.*);

  always #6 clk_i = ~clk_i;

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dashed_line_segment_generator_top failed");
      $finish;
    end
  end

  // Check every accepted segment
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_seg(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i = 1'b0;
        repeat (600) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready_i = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  function automatic logic [6*COORD_W-1:0] pack_line(longint sx, longint sy,
      longint ex, longint ey, longint on, longint off);
    return {coord_t'(off), coord_t'(on), coord_t'(ey), coord_t'(ex),
            coord_t'(sy), coord_t'(sx)};
  endfunction

  // Offer one line, optionally after an idle burst; returns at the falling edge
  task send_line(logic [6*COORD_W-1:0] d);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_line(d);
    @(negedge clk_i);
  endtask

  task wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Well-formed dashed line with random content, kept inside the range
  function automatic logic [6*COORD_W-1:0] random_line();
    longint sx, sy, dx, dy, span, r;
    r  = longint'(1) << $urandom_range(2, 22);
    sx = longint'($urandom_range(0, 24'hFFFFFF)) + CMIN;
    sy = longint'($urandom_range(0, 24'hFFFFFF)) + CMIN;
    dx = longint'($urandom_range(0, 32'(2 * r))) - r;
    dy = longint'($urandom_range(0, 32'(2 * r))) - r;
    span = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + 4;
    return pack_line(sx, sy, sb.clamp(sx + dx), sb.clamp(sy + dy),
                     longint'($urandom_range(0, 32'(span / 6))),
                     longint'($urandom_range(1, 32'(span / 6))));
  endfunction

  initial begin
    logic [6*COORD_W-1:0] d;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: solid cases, zero dash, limit, gap past end, extremes
    send_line(pack_line(100, 200, 100, 200, 50, 50));            // zero length
    send_line(pack_line(0, 0, 5000, 0, -1, 100));                // negative dash
    send_line(pack_line(0, 0, 5000, 3000, 100, 0));              // zero gap
    send_line(pack_line(0, 0, 0, 5000, 100, CMIN));              // negative gap
    send_line(pack_line(0, 0, 3000, 4000, 0, 1000));             // point dashes
    send_line(pack_line(0, 0, 100000, 0, 10, 10));               // dash limit
    send_line(pack_line(-500, 700, 90000, -40000, 0, 1));        // limit, zero dash
    send_line(pack_line(0, 0, 0, 1000, 300, 800));               // gap past end
    send_line(pack_line(0, 0, 1000, 0, 500, 500));               // gap ends exactly at end
    send_line(pack_line(0, 0, 1000, 0, CMAX, 1));                // one long dash
    send_line(pack_line(CMIN, CMIN, CMAX, CMAX, 1 << 22, 1 << 22));
    send_line(pack_line(CMAX, CMIN, CMIN, CMAX, 1 << 21, CMAX));
    send_line(pack_line(CMAX, CMAX, CMIN, CMIN, 0, 1 << 20));
    send_line(pack_line(CMIN, 0, CMAX, 0, 12345, 54321));
    send_line(pack_line(0, CMAX, 0, CMIN, 1, 3));                // limit, far line
    send_line(pack_line(-3, -4, 0, 0, 1, 1));
    send_line(pack_line(7, -9, -11, 13, 2, 5));
    send_line(pack_line(0, 0, 1, 1, 0, 1));
    send_line(pack_line(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_line(pack_line(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    wait_drained();

    // Random: mostly well-formed lines, some raw noise, pressure in the middle
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 80) hold_req = 1'b1;
      if (i == 160) wait_drained();
      if (i == NUM_RANDOM - 60) idle_on = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        for (int k = 0; k < 6; k++) d[k*COORD_W +: COORD_W] = COORD_W'($urandom());
      end else begin
        d = random_line();
      end
      send_line(d);
    end
    wait_drained();

    $display("Covered %0d lines (%0d solid), %0d segments, %0d truncated.",
             sb.lines, sb.solids, sb.segs, sb.truncs);
    if (sb.errors == 0) begin
      $display("tb_dashed_line_segment_generator_top passed");
    end else begin
      $display("tb_dashed_line_segment_generator_top failed");
    end
    $finish;
  end

endmodule

[dashed_line_segment_generator_top.f]
rtl/core/dlsg_pkg.sv
rtl/core/dlsg_front.sv
rtl/core/dlsg_queue.sv
rtl/core/dlsg_back.sv
rtl/core/dashed_line_segment_generator_top.sv
tb/sv/tb_dashed_line_segment_generator_top.sv
